// ===== rtl/core/ttb_pkg.sv =====
// Shared widths, constants and the triangle job record for the tangent unit.
// No dependencies; every other file imports it.
`default_nettype none
package ttb_pkg;

    localparam int unsigned PosW    = 32;
    localparam int unsigned TexW    = 16;
    localparam int unsigned EdgeW   = PosW + 1;
    localparam int unsigned DeltaW  = TexW + 1;
    localparam int unsigned ProdW   = EdgeW + DeltaW;
    localparam int unsigned SumW    = ProdW + 1;
    localparam int unsigned DetW    = 2 * DeltaW;
    localparam int unsigned MagW    = ProdW;
    localparam int unsigned FracSh  = 12;
    localparam int unsigned DivBits = MagW + FracSh;
    localparam int unsigned QueueDepth = 2;

    typedef logic signed [EdgeW-1:0]  edge_t;
    typedef logic signed [DeltaW-1:0] delta_t;

    typedef struct packed {
        logic [2:0][EdgeW-1:0] e1;
        logic [2:0][EdgeW-1:0] e2;
        delta_t du1;
        delta_t dv1;
        delta_t du2;
        delta_t dv2;
    } tri_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/ttb_front.sv =====
// Front end: holds the first two corners of a triangle and forms edge and UV deltas.
// Depends on ttb_pkg.
`default_nettype none
module ttb_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [ttb_pkg::PosW-1:0]   pos_x,
    input  wire logic [ttb_pkg::PosW-1:0]   pos_y,
    input  wire logic [ttb_pkg::PosW-1:0]   pos_z,
    input  wire logic [ttb_pkg::TexW-1:0]   tex_u,
    input  wire logic [ttb_pkg::TexW-1:0]   tex_v,
    output logic                            push,
    output ttb_pkg::tri_job_t               job
);
    import ttb_pkg::*;

    logic [1:0] count_reg, count_next;
    logic [1:0][2:0][PosW-1:0] pos_reg;
    logic [1:0][1:0][TexW-1:0] tex_reg;
    logic [2:0][PosW-1:0] cur;

    assign cur = {pos_z, pos_y, pos_x};
    // count three never occurs; treat it as a closing corner anyway
    assign push = accept && count_reg[1];

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_reg[1] ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !count_reg[1])
        begin
            pos_reg[count_reg[0]] <= cur;
            tex_reg[count_reg[0]] <= {tex_v, tex_u};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            job.e1[k] = {pos_reg[1][k][PosW-1], pos_reg[1][k]}
                      - {pos_reg[0][k][PosW-1], pos_reg[0][k]};
            job.e2[k] = {cur[k][PosW-1], cur[k]}
                      - {pos_reg[0][k][PosW-1], pos_reg[0][k]};
        end
        job.du1 = {tex_reg[1][0][TexW-1], tex_reg[1][0]}
                - {tex_reg[0][0][TexW-1], tex_reg[0][0]};
        job.dv1 = {tex_reg[1][1][TexW-1], tex_reg[1][1]}
                - {tex_reg[0][1][TexW-1], tex_reg[0][1]};
        job.du2 = {tex_u[TexW-1], tex_u} - {tex_reg[0][0][TexW-1], tex_reg[0][0]};
        job.dv2 = {tex_v[TexW-1], tex_v} - {tex_reg[0][1][TexW-1], tex_reg[0][1]};
    end

endmodule
`default_nettype wire

// ===== rtl/core/ttb_queue.sv =====
// Two-entry job queue between the front end and the divider back end.
// Depends on ttb_pkg.
`default_nettype none
module ttb_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ttb_pkg::tri_job_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output ttb_pkg::tri_job_t      pop_data
);
    import ttb_pkg::*;

    tri_job_t mem_reg [QueueDepth];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(QueueDepth));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ttb_back.sv =====
// Back end: shared multiplier for determinant and numerators, radix-2 divider,
// saturation and the output register. Depends on ttb_pkg.
`default_nettype none
module ttb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_valid,
    input  wire ttb_pkg::tri_job_t job_in,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [5:0][31:0]       out_vec,
    output logic                   out_degen,
    output logic                   out_sat
);
    import ttb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_SUM, ST_DIV, ST_FIX, ST_OUT
    } state_t;

    state_t state_reg;
    tri_job_t job_reg;
    logic [2:0] j_reg;
    logic [5:0] cnt_reg;
    logic signed [ProdW-1:0] prod_reg, acc_reg;
    logic signed [DetW-1:0] det_reg;
    logic [DetW-1:0] dmag_reg;
    logic [DivBits-1:0] shift_reg;
    logic [DetW-1:0] rem_reg;
    logic qneg_reg, sat_reg, degen_reg;
    logic [5:0][31:0] res_reg;

    logic signed [EdgeW-1:0] mul_a;
    logic signed [DeltaW-1:0] mul_b;
    logic signed [ProdW-1:0] mul_p;
    logic signed [SumW-1:0] sum;
    logic [SumW-1:0] sum_mag;
    logic [DetW:0] trial;
    logic fit;
    logic [31:0] fix_val;
    logic fix_sat;

    function automatic edge_t ext(input delta_t d);
        ext = {{(EdgeW-DeltaW){d[DeltaW-1]}}, d};
    endfunction

    // operands: phase A takes the positive term, phase B the subtracted one
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (j_reg)
            3'd0:
            begin
                mul_a = ext(state_reg == ST_MUL_A ? job_reg.du1 : job_reg.dv1);
                mul_b = (state_reg == ST_MUL_A) ? job_reg.dv2 : job_reg.du2;
            end
            3'd1, 3'd2, 3'd3:
            begin
                mul_a = (state_reg == ST_MUL_A) ? job_reg.e1[2'(j_reg - 3'd1)]
                                                : job_reg.e2[2'(j_reg - 3'd1)];
                mul_b = (state_reg == ST_MUL_A) ? job_reg.dv2 : job_reg.dv1;
            end
            3'd4, 3'd5, 3'd6:
            begin
                mul_a = (state_reg == ST_MUL_A) ? job_reg.e2[2'(j_reg - 3'd4)]
                                                : job_reg.e1[2'(j_reg - 3'd4)];
                mul_b = (state_reg == ST_MUL_A) ? job_reg.du1 : job_reg.du2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = ProdW'(mul_a * mul_b);
    assign sum     = SumW'(acc_reg) - SumW'(prod_reg);
    assign sum_mag = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
    assign trial   = {rem_reg, shift_reg[DivBits-1]};
    assign fit     = (trial >= {1'b0, dmag_reg});

    always_comb
    begin
        fix_sat = 1'b0;
        fix_val = shift_reg[31:0];
        if (qneg_reg)
        begin
            if ((shift_reg[DivBits-1:32] != '0) || (shift_reg[31] && shift_reg[30:0] != '0))
            begin
                fix_sat = 1'b1;
                fix_val = 32'h8000_0000;
            end
            else
            begin
                fix_val = -shift_reg[31:0];
            end
        end
        else if (shift_reg[DivBits-1:31] != '0)
        begin
            fix_sat = 1'b1;
            fix_val = 32'h7FFF_FFFF;
        end
    end

    assign pop = (state_reg == ST_IDLE) && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
            j_reg     <= 3'd0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            // raise valid on a new beat, drop it once the beat is taken
            if (state_reg == ST_OUT && (!out_valid || !out_stall))
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        j_reg     <= 3'd0;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_MUL_A:
                begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (j_reg == 3'd0)
                    begin
                        if (sum == '0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            j_reg     <= 3'd1;
                            state_reg <= ST_MUL_A;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= 6'd0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DivBits - 1))
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    if (j_reg == 3'd6)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 3'd1;
                        state_reg <= ST_MUL_A;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg   <= job_in;
                sat_reg   <= 1'b0;
                degen_reg <= 1'b0;
            end
            ST_MUL_A:
            begin
                prod_reg <= mul_p;
            end
            ST_MUL_B:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            ST_SUM:
            begin
                if (j_reg == 3'd0)
                begin
                    det_reg   <= sum[DetW-1:0];
                    dmag_reg  <= sum[SumW-1] ? DetW'(-sum) : sum[DetW-1:0];
                    degen_reg <= (sum == '0);
                    res_reg   <= '0;
                end
                else
                begin
                    shift_reg <= {sum_mag[MagW-1:0], {FracSh{1'b0}}};
                    rem_reg   <= '0;
                    qneg_reg  <= sum[SumW-1] ^ det_reg[DetW-1];
                end
            end
            ST_DIV:
            begin
                // shift dividend out, quotient bits in
                rem_reg   <= fit ? DetW'(trial - {1'b0, dmag_reg}) : trial[DetW-1:0];
                shift_reg <= {shift_reg[DivBits-2:0], fit};
            end
            ST_FIX:
            begin
                res_reg[j_reg - 3'd1] <= fix_val;
                sat_reg <= sat_reg | fix_sat;
            end
            ST_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    out_vec   <= res_reg;
                    out_degen <= degen_reg;
                    out_sat   <= sat_reg;
                end
            end
            default:
            begin
                job_reg <= job_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/triangle_tangent_bitangent_unit.sv =====
// Top level of the per-triangle tangent and bitangent unit.
// Depends on ttb_pkg, ttb_front, ttb_queue and ttb_back.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | pos_x pos_y pos_z tex_u tex_v
//  out     | out_valid | out_stall | tangent_xyz bitangent_xyz degenerate saturated
//
// Vertices are taken one per cycle while the two-entry job queue has room.
// Each triangle takes the back end through seven multiply passes (multiply A,
// multiply B, sum) plus six 62-bit radix-2 divisions and a saturate step each;
// a zero determinant finishes after the first pass.
// Reset clears the corner count, the queue and the output valid.
// A stalled output holds its beat; the back end waits, the queue keeps filling.
`default_nettype none
module triangle_tangent_bitangent_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic signed [15:0]  tex_u,
    input  wire logic signed [15:0]  tex_v,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       tangent_x,
    output logic signed [31:0]       tangent_y,
    output logic signed [31:0]       tangent_z,
    output logic signed [31:0]       bitangent_x,
    output logic signed [31:0]       bitangent_y,
    output logic signed [31:0]       bitangent_z,
    output logic                     degenerate,
    output logic                     saturated
);
    import ttb_pkg::*;

    logic accept, push, pop, full, not_empty;
    tri_job_t job_f, job_q;
    logic [5:0][31:0] vec;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    ttb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .tex_u  (tex_u),
        .tex_v  (tex_v),
        .push   (push),
        .job    (job_f)
    );

    ttb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job_f),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .pop_data  (job_q)
    );

    ttb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job_in    (job_q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_vec   (vec),
        .out_degen (degenerate),
        .out_sat   (saturated)
    );

    assign tangent_x   = vec[0];
    assign tangent_y   = vec[1];
    assign tangent_z   = vec[2];
    assign bitangent_x = vec[3];
    assign bitangent_y = vec[4];
    assign bitangent_z = vec[5];

endmodule
`default_nettype wire

// ===== tb/triangle_tangent_bitangent_unit_tb.sv =====
// Self-checking bench for triangle_tangent_bitangent_unit: a queued vertex driver,
// a tangent-basis predictor and an output monitor. Depends on ttb_pkg and the unit.
`default_nettype none
module triangle_tangent_bitangent_unit_tb;
    import ttb_pkg::*;

    typedef struct {
        logic signed [PosW-1:0] x, y, z;
        logic signed [TexW-1:0] u, v;
        bit                     hold;
    } vertex_t;

    typedef struct {
        longint field[8];
    } basis_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [PosW-1:0]  pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [TexW-1:0]  tex_u = '0, tex_v = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      tangent_x, tangent_y, tangent_z;
    logic signed [31:0]      bitangent_x, bitangent_y, bitangent_z;
    logic                    degenerate, saturated;

    vertex_t  vertex_q[$];
    basis_t   basis_due[$];
    int       beats_in = 0;
    int       triangles_out = 0;
    int       degen_seen = 0;
    int       sat_seen = 0;
    int       errors = 0;
    int       send_idle_pct, recv_stall_pct;

    logic signed [PosW-1:0]  corner_pos[2][3];
    logic signed [TexW-1:0]  corner_tex[2][2];
    int                      corners = 0;

    string field_name[8] = '{"tangent_x", "tangent_y", "tangent_z", "bitangent_x",
                             "bitangent_y", "bitangent_z", "degenerate", "saturated"};

    triangle_tangent_bitangent_unit uut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle mix changes every hundred beats: none, sender, receiver, both.
    always_comb
    begin
        case ((beats_in / 100) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    end

    function automatic longint clip_quotient(input longint num, input longint det,
                                             inout bit sat);
        longint q;
        q = (num * 4096) / det;
        if (q > 64'sd2147483647) begin sat = 1; return 64'sd2147483647; end
        if (q < -64'sd2147483648) begin sat = 1; return -64'sd2147483648; end
        return q;
    endfunction

    // Hold the first two corners; on the third, queue the expected basis.
    task automatic predict_basis(input vertex_t vx);
        longint e1[3], e2[3], p3[3];
        longint du1, dv1, du2, dv2, det;
        basis_t r;
        bit sat;
        if (corners < 2)
        begin
            corner_pos[corners] = '{vx.x, vx.y, vx.z};
            corner_tex[corners] = '{vx.u, vx.v};
            corners++;
            return;
        end
        corners = 0;
        sat = 0;
        p3 = '{longint'(vx.x), longint'(vx.y), longint'(vx.z)};
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = longint'(corner_pos[1][k]) - longint'(corner_pos[0][k]);
            e2[k] = p3[k] - longint'(corner_pos[0][k]);
        end
        du1 = longint'(corner_tex[1][0]) - longint'(corner_tex[0][0]);
        dv1 = longint'(corner_tex[1][1]) - longint'(corner_tex[0][1]);
        du2 = longint'(vx.u) - longint'(corner_tex[0][0]);
        dv2 = longint'(vx.v) - longint'(corner_tex[0][1]);
        det = du1 * dv2 - dv1 * du2;
        for (int k = 0; k < 3; k++)
        begin
            if (det == 0)
            begin
                r.field[k] = 0;
                r.field[3+k] = 0;
            end
            else
            begin
                r.field[k] = clip_quotient(e1[k] * dv2 - e2[k] * dv1, det, sat);
                r.field[3+k] = clip_quotient(e2[k] * du1 - e1[k] * du2, det, sat);
            end
        end
        r.field[6] = (det == 0);
        r.field[7] = sat;
        basis_due.push_back(r);
    endtask

    // Vertex driver: advance on an accepted beat, hold while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_basis('{pos_x, pos_y, pos_z, tex_u, tex_v, 1'b0});
                beats_in <= beats_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (vertex_q.size() > 0 && !(vertex_q[0].hold && basis_due.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    pos_x <= vertex_q[0].x;
                    pos_y <= vertex_q[0].y;
                    pos_z <= vertex_q[0].z;
                    tex_u <= vertex_q[0].u;
                    tex_v <= vertex_q[0].v;
                    in_valid <= 1'b1;
                    void'(vertex_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted beat with the oldest expected basis.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                basis_t got;
                basis_t want;
                got.field = '{longint'(tangent_x), longint'(tangent_y), longint'(tangent_z),
                              longint'(bitangent_x), longint'(bitangent_y),
                              longint'(bitangent_z), longint'(degenerate),
                              longint'(saturated)};
                if (basis_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, tangent_x=%0d", $time, tangent_x);
                    errors++;
                end
                else
                begin
                    want = basis_due.pop_front();
                    for (int k = 0; k < 8; k++)
                        if (got.field[k] !== want.field[k])
                        begin
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     field_name[k], want.field[k], got.field[k]);
                            errors++;
                        end
                    triangles_out++;
                    degen_seen += int'(want.field[6]);
                    sat_seen += int'(want.field[7]);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_vertex(input logic signed [31:0] x, y, z,
                              input logic signed [15:0] u, v, input bit hold = 0);
        vertex_q.push_back('{x, y, z, u, v, hold});
    endtask

    function automatic logic [31:0] rand_pos(input bit narrow);
        return narrow ? 32'($signed($urandom_range(8 << 16)) - (4 << 16)) : $urandom;
    endfunction

    function automatic logic [15:0] rand_tex(input bit narrow);
        return narrow ? 16'($signed($urandom_range(8192)) - 4096) : 16'($urandom);
    endfunction

    initial
    begin
        // Directed: all-zero (zero determinant), unit right triangle, negative determinant.
        repeat (3) add_vertex(0, 0, 0, 0, 0);
        add_vertex(0, 0, 0, 0, 0);
        add_vertex(32'sh10000, 0, 0, 16'sh1000, 0);
        add_vertex(0, 32'sh10000, 0, 0, 16'sh1000);
        add_vertex(0, 0, 32'sh10000, 0, 0);
        add_vertex(32'sh20000, 0, 0, 0, 16'sh1000);
        add_vertex(0, 32'sh30000, 0, 16'sh1000, 0);
        // Position extremes with a tiny determinant: saturate both ways.
        add_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, 1);
        add_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd1, 0);
        add_vertex(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 16'sd1);
        // Texture extremes, then collinear UVs (zero determinant).
        add_vertex(-32'sd5, 32'sd7, 32'sh12345678, 16'sh8000, 16'sh7fff);
        add_vertex(32'sh00ff00ff, -32'sd1, 32'sd3, 16'sh7fff, 16'sh8000);
        add_vertex(32'sd9, 32'sh7fffffff, -32'sd9, 16'sh8000, 16'sh8000);
        add_vertex(32'sd1, 32'sd2, 32'sd3, 16'sd100, 16'sd200);
        add_vertex(32'sd4, 32'sd5, 32'sd6, 16'sd200, 16'sd400);
        add_vertex(32'sd7, 32'sd8, 32'sd9, 16'sd300, 16'sd600);
        add_vertex(32'shffffffff, 32'shffffffff, 32'shffffffff, 16'shffff, 16'shffff);
        add_vertex(0, 0, 0, 16'sh7fff, 16'sh7fff);
        add_vertex(32'sh7fffffff, 0, 32'sh80000000, 16'sh8000, 16'sh7fff);
        // Random triangles, mostly modest sizes, some full-range noise.
        for (int n = 0; n < 128; n++)
            for (int c = 0; c < 3; c++)
            begin
                bit narrow;
                narrow = ($urandom_range(3) != 0);
                add_vertex(rand_pos(narrow), rand_pos(narrow), rand_pos(narrow),
                           rand_tex(narrow), rand_tex(narrow), n == 70 && c == 0);
            end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (vertex_q.size() == 0 && !in_valid);
        wait (basis_due.size() == 0);
        repeat (500) @(posedge clk);
        $display("Covered %0d vertex beats, %0d triangles (%0d degenerate, %0d saturated).",
                 beats_in, triangles_out, degen_seen, sat_seen);
        $display("Idle mixes: none, sender 45%%, receiver 45%%, both 18%%.");
        if (errors == 0 && basis_due.size() == 0)
            $display("triangle_tangent_bitangent_unit_tb OK");
        else
            $display("triangle_tangent_bitangent_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Timeout with %0d results still due.", basis_due.size());
        $display("triangle_tangent_bitangent_unit_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

// ===== triangle_tangent_bitangent_unit.f =====
rtl/core/ttb_pkg.sv
rtl/core/ttb_front.sv
rtl/core/ttb_queue.sv
rtl/core/ttb_back.sv
rtl/core/triangle_tangent_bitangent_unit.sv
tb/triangle_tangent_bitangent_unit_tb.sv
